### src/stk_pkg.sv
// shared types, constants and helpers for the soft takeover knob core
// no dependencies; imported by every module of the block
package stk_pkg;

    localparam int unsigned VAL_W  = 16;
    localparam int unsigned RATE_W = 17;

    localparam logic [RATE_W-1:0] RATE_MIN   = 17'd655;
    localparam logic [RATE_W-1:0] RATE_MAX   = 17'd65536;
    localparam logic [RATE_W-1:0] RATE_RST   = 17'd6554;
    localparam logic [VAL_W-1:0]  PICKUP_RST = 16'd1311;
    localparam logic [VAL_W-1:0]  MOVE_RST   = 16'd328;

    typedef enum logic [1:0] {
        CMD_PROCESS = 2'd0,
        CMD_PRESET  = 2'd1,
        CMD_LOCK    = 2'd2,
        CMD_NONE    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        REG_INTERP_RATE = 2'd0,
        REG_PICKUP_THR  = 2'd1,
        REG_MOVE_THR    = 2'd2,
        REG_UNUSED      = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [RATE_W-1:0] interp_rate;
        logic [VAL_W-1:0]  pickup_thr;
        logic [VAL_W-1:0]  move_thr;
    } cfg_t;

    typedef struct packed {
        logic [VAL_W-1:0] held;
        logic             locked;
        logic             first;
        logic [VAL_W-1:0] prev;
    } knob_state_t;

    function automatic logic [VAL_W-1:0] abs_diff(input logic [VAL_W-1:0] a,
                                                  input logic [VAL_W-1:0] b);
        abs_diff = (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

### src/soft_takeover_knob_core.sv
// Soft takeover (pickup) core for a potentiometer stream. Each input transaction carries a
// command and is answered by exactly one result transaction holding the parameter value and
// the moved and locked flags. One transaction per clock cycle is taken unless m_tready stalls;
// each passes input, then result register. The per-cycle path is the state feedback loop
// through one 17x18 multiply, an add, a clamp and a pickup compare. Configuration writes are
// taken in any cycle with cfg_ready held high and should be issued only while the core is idle.
// depends on stk_pkg, stk_cfg_regs and stk_step
module soft_takeover_knob_core import stk_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [31:0]       s_tdata,  // knob_sample[15:0], preset_value[31:16]
    input  logic [1:0]        s_tuser,  // cmd[1:0]
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [23:0]       m_tdata,  // out_value[15:0], moved_flag[16], locked_flag[17]
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [RATE_W-1:0] cfg_data
);

    cfg_t             cfg;
    knob_state_t      state_reg;
    knob_state_t      state_next;
    logic             in_valid_reg;
    cmd_t             cmd_reg;
    logic [VAL_W-1:0] knob_reg;
    logic [VAL_W-1:0] preset_reg;
    logic             out_valid_reg;
    logic [23:0]      out_data_reg;
    logic             moved;
    logic             advance;
    logic             fire;

    stk_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    stk_step u_step (
        .st      (state_reg),
        .cfg     (cfg),
        .cmd     (cmd_reg),
        .knob    (knob_reg),
        .preset  (preset_reg),
        .st_next (state_next),
        .moved   (moved)
    );

    // compute stage moves whenever the result register is free or being drained
    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            state_reg.held   <= '0;
            state_reg.locked <= 1'b0;
            state_reg.first  <= 1'b1;
            state_reg.prev   <= '0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
            if (fire) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            cmd_reg    <= cmd_t'(s_tuser);
            knob_reg   <= s_tdata[15:0];
            preset_reg <= s_tdata[31:16];
        end
        if (fire) begin
            out_data_reg <= {6'b0, state_next.locked, moved, state_next.held};
        end
    end

    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && out_valid_reg && !m_tready |-> !s_tready)
        else $error("input accepted while both stages are stalled");

    a_preset_locks: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && cmd_reg == CMD_PRESET |=> state_reg.locked && state_reg.first
            && state_reg.held == $past(preset_reg))
        else $error("preset did not load and lock the held value");

    a_unlocked_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && cmd_reg == CMD_PROCESS && !state_reg.locked |=>
            !state_reg.locked && state_reg.held == $past(knob_reg))
        else $error("unlocked value did not follow the knob");

    a_rate_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg.interp_rate >= RATE_MIN && cfg.interp_rate <= RATE_MAX)
        else $error("interp rate outside its clamp range");

    a_result_matches_state: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> out_data_reg[15:0] == state_reg.held && out_data_reg[17] == state_reg.locked)
        else $error("result does not reflect the updated state");

endmodule

### src/stk_cfg_regs.sv
// configuration register bank: interp rate (clamped on write) and thresholds
// depends on stk_pkg
module stk_cfg_regs import stk_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [RATE_W-1:0] cfg_data,
    output cfg_t              cfg
);

    cfg_t              cfg_reg;
    cfg_t              cfg_next;
    logic [RATE_W-1:0] rate_clamped;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        priority if (cfg_data < RATE_MIN) begin
            rate_clamped = RATE_MIN;
        end else if (cfg_data > RATE_MAX) begin
            rate_clamped = RATE_MAX;
        end else begin
            rate_clamped = cfg_data;
        end
    end

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (reg_idx_t'(cfg_index))
                REG_INTERP_RATE: cfg_next.interp_rate = rate_clamped;
                REG_PICKUP_THR:  cfg_next.pickup_thr  = cfg_data[VAL_W-1:0];
                REG_MOVE_THR:    cfg_next.move_thr    = cfg_data[VAL_W-1:0];
                REG_UNUSED:      cfg_next             = cfg_reg;
                default:         cfg_next             = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.interp_rate <= RATE_RST;
            cfg_reg.pickup_thr  <= PICKUP_RST;
            cfg_reg.move_thr    <= MOVE_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### src/stk_step.sv
// next-state and result logic for one command: lock, preset, knob sample or none (state held)
// depends on stk_pkg; purely combinational, the state lives in the top level
module stk_step import stk_pkg::*; (
    input  knob_state_t      st,
    input  cfg_t             cfg,
    input  cmd_t             cmd,
    input  logic [VAL_W-1:0] knob,
    input  logic [VAL_W-1:0] preset,
    output knob_state_t      st_next,
    output logic             moved
);

    logic signed [VAL_W:0]     knob_gap;
    logic signed [RATE_W:0]    rate_s;
    logic signed [2*VAL_W+2:0] prod;
    logic signed [VAL_W+3:0]   stepped;
    logic [VAL_W-1:0]          v_clamped;
    logic                      crossing;
    logic                      pickup;
    logic                      movement;

    assign knob_gap = $signed({1'b0, knob}) - $signed({1'b0, st.held});
    assign rate_s   = $signed({1'b0, cfg.interp_rate});
    assign prod     = knob_gap * rate_s;
    // arithmetic shift by 16 gives the floor of the q16 product
    assign stepped  = $signed({4'b0, st.held})
                    + $signed({prod[2*VAL_W+2], prod[2*VAL_W+2:VAL_W]});

    always_comb begin
        priority if (stepped < 0) begin
            v_clamped = '0;
        end else if (stepped > $signed({4'b0, {VAL_W{1'b1}}})) begin
            v_clamped = {VAL_W{1'b1}};
        end else begin
            v_clamped = stepped[VAL_W-1:0];
        end
    end

    assign crossing = !st.first && ((st.prev > st.held) != (knob > st.held));
    assign pickup   = abs_diff(knob, st.held) < cfg.pickup_thr;
    assign movement = abs_diff(knob, st.prev) > cfg.move_thr;

    always_comb begin
        st_next = st;
        moved   = 1'b0;
        unique case (cmd)
            CMD_PROCESS: begin
                st_next.prev = knob;
                if (!st.locked) begin
                    moved        = abs_diff(knob, st.held) > cfg.move_thr;
                    st_next.held = knob;
                end else begin
                    priority if (crossing) begin
                        st_next.locked = 1'b0;
                        st_next.held   = knob;
                        moved          = 1'b1;
                    end else if (pickup) begin
                        st_next.locked = 1'b0;
                        st_next.held   = knob;
                    end else if (st.first) begin
                        st_next.first = 1'b0;
                    end else if (movement) begin
                        moved = 1'b1;
                        if (abs_diff(knob, v_clamped) < cfg.pickup_thr) begin
                            st_next.locked = 1'b0;
                            st_next.held   = knob;
                        end else begin
                            st_next.held = v_clamped;
                        end
                    end else begin
                        st_next.held = st.held;
                    end
                end
            end
            CMD_PRESET: begin
                st_next.held   = preset;
                st_next.locked = 1'b1;
                st_next.first  = 1'b1;
            end
            CMD_LOCK: begin
                st_next.locked = 1'b1;
                st_next.first  = 1'b1;
            end
            CMD_NONE: begin
                st_next = st;
            end
            default: begin
                st_next = st;
            end
        endcase
    end

endmodule
